[src/mer_pkg.sv]
// Shared types and constants of the MAC exact-match redirect table.
package mer_pkg;

  localparam int EntriesDefault = 64;
  localparam int MacW           = 48;
  localparam int EdgeW          = 16;
  localparam int StatusW        = 2;

  localparam logic FuncClassify = 1'b0;
  localparam logic FuncAdd      = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_DUP  = 2'd2
  } status_e;

  // Search token that walks the row of entry cells
  typedef struct packed {
    logic             add;
    logic [MacW-1:0]  mac;
    logic [EdgeW-1:0] edge_id;
    logic             found;
  } tok_t;

endpackage

[src/mac_exact_match_redirect_table.sv]
// Top level of the MAC exact-match redirect table: cell row, fill count, result register.
//
//   channel | direction | handshake              | beat fields
//   --------+-----------+------------------------+------------------------------------------
//   in      | input     | in_valid_i/in_ready_o   | func, mac_address, edge_id, burst_end
//   out     | output    | out_valid_o/out_ready_i | out_edge, hit, status, burst_last
//
// A beat walks the row of ENTRIES cells, one cell a cycle, and its result is then held
// in the output register; the next beat is taken as that result leaves, so a new beat
// is never accepted while the last one is in the row or its result still waits to leave.
// Reset clears the fill count and the valid and busy flags only; stored entries need no sweep.
// A stalled result holds in the output register and blocks new input beats.
module mac_exact_match_redirect_table
  import mer_pkg::*;
#(
  parameter int ENTRIES = EntriesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [MacW-1:0]    mac_address_i,
  input  logic [EdgeW-1:0]   edge_id_i,
  input  logic               burst_end_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [EdgeW-1:0]   out_edge_o,
  output logic               hit_o,
  output logic [StatusW-1:0] status_o,
  output logic               burst_last_o
);

  localparam int CntW = $clog2(ENTRIES + 1);
  localparam logic [CntW-1:0] Full = CntW'(ENTRIES);

  logic [CntW-1:0]    count_q, count_d;
  logic               busy_q, busy_d;
  logic               out_valid_q, out_valid_d;
  logic               burst_q;
  logic [EdgeW-1:0]   out_edge_q, out_edge_d;
  logic               hit_q, hit_d;
  status_e            status_q, status_d;
  logic               in_fire, out_fire, tok_exit, full;

  logic               vld [ENTRIES+1];
  tok_t               tok [ENTRIES+1];

  assign in_ready_o = !busy_q && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;
  assign full       = (count_q == Full);

  assign vld[0]         = in_fire;
  assign tok[0].add     = (func_i == FuncAdd);
  assign tok[0].mac     = mac_address_i;
  assign tok[0].edge_id = edge_id_i;
  assign tok[0].found   = 1'b0;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    mer_cell #(
      .IDX  (k),
      .CntW (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .count_i (count_q),
      .vld_i   (vld[k]),
      .tok_i   (tok[k]),
      .vld_o   (vld[k+1]),
      .tok_o   (tok[k+1])
    );
  end

  assign tok_exit = vld[ENTRIES];

  always_comb begin
    count_d     = count_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    out_edge_d  = out_edge_q;
    hit_d       = hit_q;
    status_d    = status_q;
    if (in_fire) begin
      busy_d = 1'b1;
    end
    if (out_fire) begin
      out_valid_d = 1'b0;
    end
    if (tok_exit) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
      out_edge_d  = '0;
      hit_d       = 1'b0;
      status_d    = ST_OK;
      if (tok[ENTRIES].add) begin
        if (full) begin
          status_d = ST_FULL;
        end else if (tok[ENTRIES].found) begin
          status_d = ST_DUP;
        end else begin
          count_d = count_q + 1'b1;
        end
      end else if (tok[ENTRIES].found) begin
        out_edge_d = tok[ENTRIES].edge_id;
        hit_d      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // hold the burst mark for the beat in flight
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      burst_q <= burst_end_i;
    end
    out_edge_q <= out_edge_d;
    hit_q      <= hit_d;
    status_q   <= status_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_edge_o   = out_edge_q;
  assign hit_o        = hit_q;
  assign status_o     = status_q;
  assign burst_last_o = burst_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("fill count above table size");

  a_exit_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_exit |-> busy_q && !out_valid_q)
    else $error("token left the row with no beat in flight or result pending");

  a_hit_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && hit_q |-> status_q == ST_OK)
    else $error("hit reported with error status");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |-> $past(tok_exit) && $past(tok[ENTRIES].add))
    else $error("fill count moved without an append");

endmodule

[src/mer_cell.sv]
// One table entry: stored address and edge, compare against the passing token.
module mer_cell
  import mer_pkg::*;
#(
  parameter int IDX  = 0,
  parameter int CntW = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CntW-1:0] count_i,
  input  logic            vld_i,
  input  tok_t            tok_i,
  output logic            vld_o,
  output tok_t            tok_o
);

  localparam logic [CntW-1:0] IdxC = CntW'(IDX);

  logic [MacW-1:0]  mac_q;
  logic [EdgeW-1:0] edge_q;
  logic             vld_q;
  tok_t             tok_q, tok_d;
  logic             active, match, wr_en;

  // entries at or beyond the fill count are never compared
  assign active = count_i > IdxC;
  assign match  = active && (mac_q == tok_i.mac);
  // append lands here once every older entry has been checked
  assign wr_en  = vld_i && tok_i.add && !tok_i.found && (count_i == IdxC);

  always_comb begin
    tok_d       = tok_i;
    tok_d.found = tok_i.found | match;
    if (!tok_i.add && match) begin
      tok_d.edge_id = edge_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mac_q  <= tok_i.mac;
      edge_q <= tok_i.edge_id;
    end
    tok_q <= tok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;

endmodule
